// File: design/type_varint_length_deframer_unit_assert.svh
// Assertion macros shared by the deframer checker.
// Depends on nothing; included by the checker file by bare file name.
`ifndef TYPE_VARINT_LENGTH_DEFRAMER_UNIT_ASSERT_SVH
`define TYPE_VARINT_LENGTH_DEFRAMER_UNIT_ASSERT_SVH

// Clocked assertion that is switched off while reset is asserted.
`define TVLD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define TVLD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/tvld_pkg.sv
// Shared types and constants of the type/varint-length deframer.
// Used by the interfaces, the top level and the checker; depends on nothing.
package tvld_pkg;

  localparam int unsigned MaxLengthBytesDefault = 5;

  localparam int unsigned ByteW         = 8;
  localparam int unsigned RoleW         = 2;
  localparam int unsigned LenW          = 32;
  localparam int unsigned LenCntW       = 3;
  localparam int unsigned VarintDataBits = 7;
  localparam int unsigned ShiftW        = 6;

  typedef enum logic [RoleW-1:0] {
    ROLE_TYPE    = 2'd0,
    ROLE_LENGTH  = 2'd1,
    ROLE_PAYLOAD = 2'd2,
    ROLE_ERROR   = 2'd3
  } role_e;

  // The fourth code is unused and behaves like PH_TYPE.
  typedef enum logic [1:0] {
    PH_TYPE = 2'd0,
    PH_LEN  = 2'd1,
    PH_PAY  = 2'd2
  } phase_e;

  typedef struct packed {
    role_e               byte_role;
    logic [ByteW-1:0]    byte_out;
    logic [ByteW-1:0]    message_kind;
    logic [LenW-1:0]     decoded_len;
    logic [LenCntW-1:0]  length_bytes;
    logic                length_valid;
    logic                message_end;
    logic                length_error;
  } result_t;

endpackage

// File: design/tvld_if.sv
// Valid/ready channel interfaces for the deframer: input bytes and labeled results.
// Depends on tvld_pkg for field widths.
interface tvld_byte_if;
  logic                       valid;
  logic                       ready;
  logic [tvld_pkg::ByteW-1:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface tvld_result_if;
  logic                         valid;
  logic                         ready;
  logic [tvld_pkg::RoleW-1:0]   byte_role;
  logic [tvld_pkg::ByteW-1:0]   byte_out;
  logic [tvld_pkg::ByteW-1:0]   message_kind;
  logic [tvld_pkg::LenW-1:0]    decoded_len;
  logic [tvld_pkg::LenCntW-1:0] length_bytes;
  logic                         length_valid;
  logic                         message_end;
  logic                         length_error;

  modport source (output valid, output byte_role, output byte_out, output message_kind,
                  output decoded_len, output length_bytes, output length_valid,
                  output message_end, output length_error, input ready);
  modport sink   (input valid, input byte_role, input byte_out, input message_kind,
                  input decoded_len, input length_bytes, input length_valid,
                  input message_end, input length_error, output ready);
endinterface

// File: design/type_varint_length_deframer_unit.sv
// Type / varint-length / payload deframer. Each message on the byte stream starts
// with a type byte, followed by a little-endian base-128 varint length (seven data
// bits per byte, bit 7 set while more length bytes follow), followed by exactly that
// many payload bytes. Every accepted input word produces one result word that labels
// the byte with its role and carries the message type, the length decoded so far,
// the count of length bytes, and flags for a complete length, the last byte of the
// message and an overlong varint. A zero length ends the message on its final length
// byte. A varint still continuing on its MAX_LENGTH_BYTES-th byte is flagged as an
// error and the next byte is taken as a new type byte; length bits landing above
// bit 31 are dropped. Throughput is one byte per clock while the result is not
// stalled: the phase registers are updated by a single pass of logic (one 32-bit
// shift-and-or, one decrement and compare) between the input register and the
// result register; each accepted word passes through both. The input register lets
// one more word enter while a result is stalled at the output.
// Depends on tvld_pkg and the channel interfaces in tvld_if.sv.
module type_varint_length_deframer_unit #(
  parameter int unsigned MAX_LENGTH_BYTES = tvld_pkg::MaxLengthBytesDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  tvld_byte_if.sink            byte_i,
  tvld_result_if.source        result_o
);

  localparam logic [tvld_pkg::LenCntW-1:0] MaxCnt =
    tvld_pkg::LenCntW'(MAX_LENGTH_BYTES);

  // Input register.
  logic                       in_valid_q;
  logic [tvld_pkg::ByteW-1:0] in_byte_q;

  // Result register.
  logic                       out_valid_q;
  tvld_pkg::result_t          res_q, res_d;

  // Message state.
  tvld_pkg::phase_e             phase_q, phase_d;
  logic [tvld_pkg::ByteW-1:0]   held_type_q, held_type_d;
  logic [tvld_pkg::LenW-1:0]    length_accum_q, length_accum_d;
  logic [tvld_pkg::LenCntW-1:0] length_count_q, length_count_d;
  logic [tvld_pkg::LenW-1:0]    bytes_remaining_q, bytes_remaining_d;

  logic advance;
  logic fire;

  // The result register can take a new word when it is empty or being drained.
  // The input register in turn refills whenever its word moves on.
  assign advance      = !out_valid_q || result_o.ready;
  assign fire         = in_valid_q && advance;
  assign byte_i.ready = !in_valid_q || advance;

  // Shared datapath terms for the current byte.
  logic [tvld_pkg::ShiftW-1:0]  shift_amt;
  logic [tvld_pkg::LenW-1:0]    len_merge;
  logic [tvld_pkg::LenCntW-1:0] cnt_inc;
  logic [tvld_pkg::LenW-1:0]    rem_dec;
  logic                         cont_bit;

  // Each length byte lands seven bits higher than the one before. A shift that
  // reaches past bit 31 leaves nothing, which is the wrap modulo 2^32.
  assign shift_amt = tvld_pkg::ShiftW'(length_count_q) *
                     tvld_pkg::ShiftW'(tvld_pkg::VarintDataBits);
  assign len_merge = length_accum_q |
                     (tvld_pkg::LenW'(in_byte_q[tvld_pkg::VarintDataBits-1:0]) << shift_amt);
  assign cnt_inc   = length_count_q + tvld_pkg::LenCntW'(1);
  assign rem_dec   = bytes_remaining_q - tvld_pkg::LenW'(1);
  assign cont_bit  = in_byte_q[tvld_pkg::ByteW-1];

  // Next-state logic of the message phase and its bookkeeping.
  always_comb begin
    phase_d           = phase_q;
    held_type_d       = held_type_q;
    length_accum_d    = length_accum_q;
    length_count_d    = length_count_q;
    bytes_remaining_d = bytes_remaining_q;
    case (phase_q)
      tvld_pkg::PH_LEN: begin
        length_accum_d = len_merge;
        length_count_d = cnt_inc;
        if (!cont_bit) begin
          if (len_merge == '0) begin
            phase_d = tvld_pkg::PH_TYPE;
          end else begin
            bytes_remaining_d = len_merge;
            phase_d           = tvld_pkg::PH_PAY;
          end
        end else if (cnt_inc >= MaxCnt) begin
          phase_d = tvld_pkg::PH_TYPE;
        end
      end
      tvld_pkg::PH_PAY: begin
        bytes_remaining_d = rem_dec;
        if (rem_dec == '0) begin
          phase_d = tvld_pkg::PH_TYPE;
        end
      end
      default: begin
        // Type byte; the unused phase code lands here as well.
        held_type_d       = in_byte_q;
        length_accum_d    = '0;
        length_count_d    = '0;
        bytes_remaining_d = '0;
        phase_d           = tvld_pkg::PH_LEN;
      end
    endcase
  end

  // Result word for the current byte.
  always_comb begin
    res_d.byte_role      = tvld_pkg::ROLE_TYPE;
    res_d.byte_out       = in_byte_q;
    res_d.message_kind   = held_type_q;
    res_d.decoded_len    = len_merge;
    res_d.length_bytes   = cnt_inc;
    res_d.length_valid   = 1'b0;
    res_d.message_end    = 1'b0;
    res_d.length_error   = 1'b0;
    case (phase_q)
      tvld_pkg::PH_LEN: begin
        if (!cont_bit) begin
          res_d.byte_role    = tvld_pkg::ROLE_LENGTH;
          res_d.length_valid = 1'b1;
          res_d.message_end  = (len_merge == '0);
        end else if (cnt_inc >= MaxCnt) begin
          res_d.byte_role    = tvld_pkg::ROLE_ERROR;
          res_d.message_end  = 1'b1;
          res_d.length_error = 1'b1;
        end else begin
          res_d.byte_role = tvld_pkg::ROLE_LENGTH;
        end
      end
      tvld_pkg::PH_PAY: begin
        res_d.byte_role      = tvld_pkg::ROLE_PAYLOAD;
        res_d.decoded_len    = length_accum_q;
        res_d.length_bytes   = length_count_q;
        res_d.length_valid   = 1'b1;
        res_d.message_end    = (rem_dec == '0);
      end
      default: begin
        // A type byte reports its own value as the message type.
        res_d.message_kind   = in_byte_q;
        res_d.decoded_len    = '0;
        res_d.length_bytes   = '0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q        <= 1'b0;
      out_valid_q       <= 1'b0;
      phase_q           <= tvld_pkg::PH_TYPE;
      held_type_q       <= '0;
      length_accum_q    <= '0;
      length_count_q    <= '0;
      bytes_remaining_q <= '0;
    end else begin
      if (byte_i.ready) begin
        in_valid_q <= byte_i.valid;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
      if (fire) begin
        phase_q           <= phase_d;
        held_type_q       <= held_type_d;
        length_accum_q    <= length_accum_d;
        length_count_q    <= length_count_d;
        bytes_remaining_q <= bytes_remaining_d;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (byte_i.valid && byte_i.ready) begin
      in_byte_q <= byte_i.data_byte;
    end
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign result_o.valid          = out_valid_q;
  assign result_o.byte_role      = res_q.byte_role;
  assign result_o.byte_out       = res_q.byte_out;
  assign result_o.message_kind   = res_q.message_kind;
  assign result_o.decoded_len    = res_q.decoded_len;
  assign result_o.length_bytes   = res_q.length_bytes;
  assign result_o.length_valid   = res_q.length_valid;
  assign result_o.message_end    = res_q.message_end;
  assign result_o.length_error   = res_q.length_error;

endmodule

// File: design/tvld_checker.sv
// Port-level checker for the deframer, attached to the top level by bind.
// Depends on tvld_pkg and the macros in type_varint_length_deframer_unit_assert.svh.
`include "type_varint_length_deframer_unit_assert.svh"

module tvld_checker #(
  parameter int unsigned MAX_LENGTH_BYTES = tvld_pkg::MaxLengthBytesDefault
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [tvld_pkg::RoleW-1:0]   byte_role_i,
  input logic [tvld_pkg::LenW-1:0]    decoded_len_i,
  input logic [tvld_pkg::LenCntW-1:0] length_bytes_i,
  input logic                         length_valid_i,
  input logic                         message_end_i,
  input logic                         length_error_i
);

  localparam logic [tvld_pkg::LenCntW-1:0] MaxCnt =
    tvld_pkg::LenCntW'(MAX_LENGTH_BYTES);

  // A stalled result must not change.
  `TVLD_ASSERT(a_hold_stalled, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i && $stable(byte_role_i) && $stable(decoded_len_i), "result changed while stalled")

  // An overlong varint is an error word that ends the message without a valid length.
  `TVLD_ASSERT(a_error_ends, clk_i, rst_ni, out_valid_i && length_error_i |-> message_end_i && !length_valid_i && byte_role_i == tvld_pkg::ROLE_ERROR && length_bytes_i == MaxCnt, "bad error word")

  // A type byte carries no length information.
  `TVLD_ASSERT(a_type_clean, clk_i, rst_ni, out_valid_i && byte_role_i == tvld_pkg::ROLE_TYPE |-> decoded_len_i == '0 && length_bytes_i == '0 && !length_valid_i && !message_end_i, "type byte with length fields")

  // Payload bytes only follow a complete, nonzero length.
  `TVLD_ASSERT(a_payload_len, clk_i, rst_ni, out_valid_i && byte_role_i == tvld_pkg::ROLE_PAYLOAD |-> length_valid_i && decoded_len_i != '0 && length_bytes_i != '0 && length_bytes_i <= MaxCnt, "payload byte without a decoded length")

  // The result channel shows nothing while in reset.
  `TVLD_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |-> !out_valid_i, "result valid during reset")

endmodule

bind type_varint_length_deframer_unit tvld_checker #(
  .MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)
) u_tvld_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (result_o.valid),
  .out_ready_i      (result_o.ready),
  .byte_role_i      (result_o.byte_role),
  .decoded_len_i    (result_o.decoded_len),
  .length_bytes_i   (result_o.length_bytes),
  .length_valid_i   (result_o.length_valid),
  .message_end_i    (result_o.message_end),
  .length_error_i   (result_o.length_error)
);
